// ===== rtl/equal_gap_run_census_top_defines.svh =====
// Assertion helpers used by the census RTL.
`ifndef EQUAL_GAP_RUN_CENSUS_TOP_DEFINES_SVH
`define EQUAL_GAP_RUN_CENSUS_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EGRC_ASSERT_NOW(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define EGRC_ASSERT_NEXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/egrc_pkg.sv =====
package egrc_pkg;

  localparam int VAL_W = 40;
  localparam int LEN_W = 16;
  localparam int OP_W  = 2;
  localparam int RL_W  = 4;
  localparam int RG_W  = 8;
  localparam int CFG_IDX_W = 1;

  localparam int DEF_GAP_LIMIT  = 256;
  localparam int DEF_LENGTH_CAP = 12;

  localparam int MIN_RUN  = 3;
  localparam int LONG_RUN = 6;

  localparam logic [VAL_W-1:0] VAL_MAX  = {VAL_W{1'b1}};
  localparam logic [LEN_W-1:0] LEN_MAX  = {LEN_W{1'b1}};
  localparam logic [VAL_W-1:0] UB_RESET = 40'd32000000000;
  localparam logic [VAL_W-1:0] CP_RESET = 40'd1000000;

  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CHECKPOINT = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_MEMBER = 2'd0,
    OP_FINISH = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    logic [RL_W-1:0]  read_length;
    logic [RG_W-1:0]  read_gap;
  } req_item_t;

  typedef struct packed {
    logic             accepted;
    logic [LEN_W-1:0] run_length;
    logic [VAL_W-1:0] run_gap;
    logic [VAL_W-1:0] run_start;
    logic [VAL_W-1:0] member_count;
    logic             new_record;
    logic             long_run;
    logic             first_seen;
    logic             density_mark;
    logic [VAL_W-1:0] runs_count;
    logic [VAL_W-1:0] earliest_start;
  } rsp_item_t;

endpackage

// ===== rtl/egrc_req_if.sv =====
interface egrc_req_if;
  logic                 valid;
  logic                 ready;
  egrc_pkg::req_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/egrc_rsp_if.sv =====
interface egrc_rsp_if;
  logic                 valid;
  logic                 ready;
  egrc_pkg::rsp_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/equal_gap_run_census_top.sv =====
// An item moves through the p1 and p2 registers to the output register, waiting in p2 while
// the output is held. The read-modify-write on the two table memories (read issued from p1,
//   written back from p2) ends before the next item's read.
// Reset (rst, synchronous): run state and registers take their reset values, then a clearing
//   pass zeroes both tables, one entry per cycle, over (LENGTH_CAP-2)*GAP_LIMIT entries (2560 by
//   default); no item is accepted during it, configuration writes are taken.
`include "equal_gap_run_census_top_defines.svh"

module equal_gap_run_census_top #(
  parameter int GAP_LIMIT  = egrc_pkg::DEF_GAP_LIMIT,
  parameter int LENGTH_CAP = egrc_pkg::DEF_LENGTH_CAP
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [egrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [egrc_pkg::VAL_W-1:0]      cfg_data,
  egrc_req_if.sink                        req,
  egrc_rsp_if.source                      rsp
);

  localparam int VAL_W  = egrc_pkg::VAL_W;
  localparam int LEN_W  = egrc_pkg::LEN_W;
  localparam int OP_W   = egrc_pkg::OP_W;
  localparam int RL_W   = egrc_pkg::RL_W;
  localparam int RG_W   = egrc_pkg::RG_W;
  localparam int DEPTH  = (LENGTH_CAP - 2) * GAP_LIMIT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int GAP_W  = $clog2(GAP_LIMIT);

  typedef struct packed {
    logic              close_en;
    logic              first_cand;
    logic              rd_ok;
    logic [ADDR_W-1:0] cnt_waddr;
    logic [ADDR_W-1:0] fs_waddr;
    logic [VAL_W-1:0]  first_val;
  } p2_ctl_t;

  function automatic logic [ADDR_W-1:0] slot_of(input logic [LEN_W-1:0] len,
                                                input logic [GAP_W-1:0] col);
    logic [LEN_W-1:0] row;
    row = (len >= LEN_W'(LENGTH_CAP)) ? LEN_W'(LENGTH_CAP - egrc_pkg::MIN_RUN)
                                      : len - LEN_W'(egrc_pkg::MIN_RUN);
    return ADDR_W'(row) * ADDR_W'(GAP_LIMIT) + ADDR_W'(col);
  endfunction

  function automatic logic qualifies(input logic [LEN_W-1:0] len,
                                     input logic [VAL_W-1:0] gap);
    return (len >= LEN_W'(egrc_pkg::MIN_RUN)) && (gap < VAL_W'(GAP_LIMIT));
  endfunction

  // configuration and run state
  logic [VAL_W-1:0] upper_bound;
  logic [VAL_W-1:0] last_member;
  logic [VAL_W-1:0] cur_gap;
  logic [VAL_W-1:0] cur_start;
  logic [VAL_W-1:0] members_seen;
  logic [VAL_W-1:0] next_mark;
  logic [LEN_W-1:0] cur_run;
  logic [LEN_W-1:0] best_run;

  // table clearing pass
  logic              clr_active;
  logic [ADDR_W-1:0] clr_addr;

  // item state held in p1
  logic             p1_valid;
  logic [OP_W-1:0]  p1_op;
  logic [VAL_W-1:0] p1_value;
  logic [RL_W-1:0]  p1_rl;
  logic [RG_W-1:0]  p1_rg;
  logic             p1_inrange;
  logic [VAL_W-1:0] p1_gap;

  // item state held in p2
  logic                p2_valid;
  p2_ctl_t             p2_ctl;
  egrc_pkg::rsp_item_t p2_item;

  // output register
  logic                out_valid;
  egrc_pkg::rsp_item_t out_item;

  logic accept;
  logic out_free;
  logic p2_fire;

  logic             acc;
  logic             has_prev;
  logic             close_en;
  logic             first_cand;
  logic             rec;
  logic             long_flag;
  logic             dens;
  logic             rd_ok;
  logic [LEN_W-1:0] run_ext;
  logic [LEN_W-1:0] run_n;
  logic [VAL_W-1:0] gap_n;
  logic [VAL_W-1:0] start_n;
  logic [VAL_W-1:0] cnt_inc;
  logic [VAL_W-1:0] cnt_n;
  logic [VAL_W-1:0] mark_dbl;

  logic [ADDR_W-1:0] close_slot;
  logic [ADDR_W-1:0] first_slot;
  logic [ADDR_W-1:0] read_slot;
  logic [ADDR_W-1:0] cnt_raddr;
  logic [ADDR_W-1:0] fs_raddr;

  logic [VAL_W-1:0]  cnt_mem [DEPTH];
  logic [VAL_W-1:0]  fs_mem  [DEPTH];
  logic [VAL_W-1:0]  cnt_rdata;
  logic [VAL_W-1:0]  fs_rdata;
  logic              cnt_we;
  logic              fs_we;
  logic              fs_hit;
  logic [ADDR_W-1:0] cnt_waddr;
  logic [ADDR_W-1:0] fs_waddr;
  logic [VAL_W-1:0]  cnt_wdata;
  logic [VAL_W-1:0]  fs_wdata;

  egrc_pkg::rsp_item_t out_next;

  // handshake: one item in the read-modify-write at a time
  assign out_free  = !out_valid || rsp.ready;
  assign p2_fire   = p2_valid && out_free;
  assign req.ready = !clr_active && !p1_valid && (!p2_valid || out_free);
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= accept;
    end
  end

  // filter and gap are taken at accept; last_member is settled by then
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_op      <= req.payload.op;
      p1_value   <= req.payload.value;
      p1_rl      <= req.payload.read_length;
      p1_rg      <= req.payload.read_gap;
      p1_inrange <= (req.payload.value != '0) && (req.payload.value <= upper_bound);
      p1_gap     <= req.payload.value - last_member;
    end
  end

  // run update for the item in p1
  assign has_prev = (last_member != '0);
  assign run_ext  = (cur_run == egrc_pkg::LEN_MAX) ? cur_run : cur_run + LEN_W'(1);
  assign cnt_inc  = members_seen + VAL_W'(1);
  assign mark_dbl = (next_mark > (egrc_pkg::VAL_MAX >> 1)) ? egrc_pkg::VAL_MAX
                                                          : (next_mark << 1);

  always_comb begin
    acc        = 1'b0;
    close_en   = 1'b0;
    first_cand = 1'b0;
    rec        = 1'b0;
    long_flag  = 1'b0;
    dens       = 1'b0;
    rd_ok      = 1'b0;
    run_n      = cur_run;
    gap_n      = cur_gap;
    start_n    = cur_start;
    cnt_n      = members_seen;
    case (p1_op)
      egrc_pkg::OP_MEMBER: begin
        if (p1_inrange) begin
          acc   = 1'b1;
          cnt_n = cnt_inc;
          dens  = (cnt_inc == next_mark);
          if (has_prev) begin
            if (p1_gap == cur_gap) begin
              run_n = run_ext;
              // once the length is pinned, the start slides by one gap
              if (cur_run == egrc_pkg::LEN_MAX) begin
                start_n = cur_start + cur_gap;
              end
            end else begin
              close_en = qualifies(cur_run, cur_gap);
              run_n    = LEN_W'(2);
              gap_n    = p1_gap;
              start_n  = last_member;
            end
            first_cand = qualifies(run_n, gap_n);
            rec        = (run_n > best_run);
            long_flag  = (run_n >= LEN_W'(egrc_pkg::LONG_RUN)) && (gap_n < VAL_W'(GAP_LIMIT));
          end else begin
            start_n = p1_value;
          end
        end
      end
      egrc_pkg::OP_FINISH: begin
        close_en = qualifies(cur_run, cur_gap);
      end
      egrc_pkg::OP_READ: begin
        rd_ok = (p1_rl >= RL_W'(egrc_pkg::MIN_RUN)) && (VAL_W'(p1_rg) < VAL_W'(GAP_LIMIT));
      end
      default: begin
      end
    endcase
  end

  assign close_slot = slot_of(cur_run, cur_gap[GAP_W-1:0]);
  assign first_slot = slot_of(run_n, gap_n[GAP_W-1:0]);
  assign read_slot  = slot_of(LEN_W'(p1_rl), GAP_W'(p1_rg));
  assign cnt_raddr  = (p1_op == egrc_pkg::OP_READ) ? read_slot : close_slot;
  assign fs_raddr   = (p1_op == egrc_pkg::OP_READ) ? read_slot : first_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_bound  <= egrc_pkg::UB_RESET;
      last_member  <= '0;
      cur_gap      <= '0;
      cur_start    <= '0;
      cur_run      <= LEN_W'(1);
      best_run     <= '0;
      members_seen <= '0;
      next_mark    <= egrc_pkg::CP_RESET;
    end else begin
      if (p1_valid) begin
        if (acc) begin
          last_member  <= p1_value;
          cur_run      <= run_n;
          cur_gap      <= gap_n;
          cur_start    <= start_n;
          members_seen <= cnt_n;
          if (rec) begin
            best_run <= run_n;
          end
          if (dens) begin
            next_mark <= mark_dbl;
          end
        end
        if (p1_op == egrc_pkg::OP_FINISH) begin
          cur_run   <= LEN_W'(1);
          cur_gap   <= '0;
          cur_start <= last_member;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          egrc_pkg::CFG_UPPER_BOUND:      upper_bound <= cfg_data;
          egrc_pkg::CFG_FIRST_CHECKPOINT: next_mark   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // hand off to p2; p2 is always empty while p1 is busy
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (p1_valid) begin
      p2_valid <= 1'b1;
    end else if (p2_fire) begin
      p2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_valid) begin
      p2_ctl.close_en           <= close_en;
      p2_ctl.first_cand         <= first_cand;
      p2_ctl.rd_ok              <= rd_ok;
      p2_ctl.cnt_waddr          <= close_slot;
      p2_ctl.fs_waddr           <= first_slot;
      p2_ctl.first_val          <= start_n;
      p2_item.accepted          <= acc;
      p2_item.run_length        <= run_n;
      p2_item.run_gap           <= gap_n;
      p2_item.run_start         <= start_n;
      p2_item.member_count      <= cnt_n;
      p2_item.new_record        <= rec;
      p2_item.long_run          <= long_flag;
      p2_item.density_mark      <= dens;
      p2_item.first_seen        <= 1'b0;
      p2_item.runs_count        <= '0;
      p2_item.earliest_start    <= '0;
    end
  end

  // table clearing after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clr_active <= 1'b0;
      end else begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  // write-back from p2
  assign fs_hit    = p2_ctl.first_cand && (fs_rdata == '0);
  assign cnt_we    = clr_active || (p2_fire && p2_ctl.close_en);
  assign fs_we     = clr_active || (p2_fire && fs_hit);
  assign cnt_waddr = clr_active ? clr_addr : p2_ctl.cnt_waddr;
  assign fs_waddr  = clr_active ? clr_addr : p2_ctl.fs_waddr;
  assign cnt_wdata = clr_active ? '0 : cnt_rdata + VAL_W'(1);
  assign fs_wdata  = clr_active ? '0 : p2_ctl.first_val;

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (p1_valid) begin
      cnt_rdata <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[fs_waddr] <= fs_wdata;
    end
    if (p1_valid) begin
      fs_rdata <= fs_mem[fs_raddr];
    end
  end

  always_comb begin
    out_next                = p2_item;
    out_next.first_seen     = fs_hit;
    out_next.runs_count     = p2_ctl.rd_ok ? cnt_rdata : '0;
    out_next.earliest_start = p2_ctl.rd_ok ? fs_rdata : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p2_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_fire) begin
      out_item <= out_next;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_item;

  `EGRC_ASSERT_NOW(a_one_in_rmw, clk, rst, p1_valid, !p2_valid,
                   "two items overlap in the table read-modify-write")
  `EGRC_ASSERT_NEXT(a_p1_moves_on, clk, rst, p1_valid, p2_valid,
                    "item did not reach its write-back cycle")
  `EGRC_ASSERT_NOW(a_clear_full, clk, rst, $fell(clr_active),
                   $past(clr_addr) == ADDR_W'(DEPTH - 1),
                   "clearing pass ended before the last table entry")
  `EGRC_ASSERT_NEXT(a_best_grows, clk, rst, 1'b1, best_run >= $past(best_run),
                    "record run length decreased")

endmodule
